// File: rtl/efd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package efd_pkg;

    localparam int BODY_BYTES = 64;
    localparam int ADDR_W     = $clog2(BODY_BYTES);
    localparam int IDX_W      = $clog2(BODY_BYTES + 1);
    localparam int PLEN_W     = 6;
    localparam int BYTE_W     = 8;
    localparam int CRC_W      = 16;
    localparam int CNT_W      = 32;
    localparam int KIND_W     = 2;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_INIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_MASK = 2'd2;

    localparam logic [CRC_W-1:0]  CRC_POLY_RST = 16'h8005;
    localparam logic [CRC_W-1:0]  CRC_INIT_RST = 16'hd77f;
    localparam logic [BYTE_W-1:0] ESC_MASK_RST = 8'h80;

    localparam logic [BYTE_W-1:0] MAGIC_BYTE  = 8'hfd;
    localparam logic [BYTE_W-1:0] ESCAPE_BYTE = 8'hfc;

    localparam logic [KIND_W-1:0] EV_GOOD    = 2'd0;
    localparam logic [KIND_W-1:0] EV_CRC_ERR = 2'd1;
    localparam logic [KIND_W-1:0] EV_TRUNC   = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_BODY   = 3'd3,
        PH_CRC_HI = 3'd4,
        PH_CRC_LO = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        EM_IDLE = 2'd0,
        EM_READ = 2'd1,
        EM_LOAD = 2'd2
    } emit_state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } efd_mem_req_t;

endpackage

`default_nettype wire

// File: rtl/efd_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface efd_byte_if
    import efd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/efd_event_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface efd_event_if
    import efd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] event_kind;
    logic [BYTE_W-1:0] dest_byte;
    logic [BYTE_W-1:0] counter_byte;
    logic [BYTE_W-1:0] payload_byte;
    logic [PLEN_W-1:0] payload_length;
    logic              has_payload;
    logic              last_of_run;
    logic [CNT_W-1:0]  ok_total;
    logic [CNT_W-1:0]  crc_error_total;
    logic [CNT_W-1:0]  truncated_total;
    logic [CNT_W-1:0]  skipped_total;

    modport source (
        output valid, output event_kind, output dest_byte, output counter_byte,
        output payload_byte, output payload_length, output has_payload,
        output last_of_run, output ok_total, output crc_error_total,
        output truncated_total, output skipped_total,
        input ready
    );
    modport sink (
        input valid, input event_kind, input dest_byte, input counter_byte,
        input payload_byte, input payload_length, input has_payload,
        input last_of_run, input ok_total, input crc_error_total,
        input truncated_total, input skipped_total,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/efd_body_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Body buffer: one write port, one read port, registered read data.
// Writes happen only while a body arrives and reads only during a payload
// burst, so the two ports never touch the same entry in the same cycle.
module efd_body_store
    import efd_pkg::*;
(
    input  wire logic         clk,
    input  wire efd_mem_req_t req,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [BODY_BYTES];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // hold the last read word until the next read request
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/escaped_frame_decoder_crc16_core.sv
`timescale 1ns / 1ps
`default_nettype none

// An error or empty-frame result is loaded at the edge that accepts its byte; the first
// payload byte of a good frame follows its closing CRC byte through EM_READ and EM_LOAD.
// Throughput: one received byte per cycle while the output slot is free; a good frame's
// payload leaves one byte per body buffer read and load, and holds off input.
// Reset (rst_n low, asynchronous): hunt for magic, counters zero, config to defaults.
// The body buffer is not cleared; only entries written in the current frame are read.
module escaped_frame_decoder_crc16_core
    import efd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    efd_byte_if.sink                  rx,
    efd_event_if.source               ev
);

    function automatic logic [CRC_W-1:0] crc_feed(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < BYTE_W; i++)
        begin
            c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ poly) : {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

    // configuration
    logic [CRC_W-1:0]  poly_reg;
    logic [CRC_W-1:0]  init_reg;
    logic [BYTE_W-1:0] mask_reg;

    // parser state
    phase_t            phase_reg, phase_next;
    logic              esc_reg, esc_next;
    logic [BYTE_W-1:0] len_hi_reg, len_hi_next;
    logic [IDX_W-1:0]  frame_len_reg, frame_len_next;
    logic [IDX_W-1:0]  body_pos_reg, body_pos_next;
    logic [BYTE_W-1:0] crc_hi_reg, crc_hi_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [BYTE_W-1:0] dest_reg, dest_next;
    logic [BYTE_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0]  ok_cnt_reg, ok_cnt_next;
    logic [CNT_W-1:0]  crc_err_cnt_reg, crc_err_cnt_next;
    logic [CNT_W-1:0]  trunc_cnt_reg, trunc_cnt_next;
    logic [CNT_W-1:0]  skip_cnt_reg, skip_cnt_next;

    // payload burst
    emit_state_t       em_reg, em_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] kind_reg;
    logic [BYTE_W-1:0] dest_out_reg;
    logic [BYTE_W-1:0] cnt_out_reg;
    logic [BYTE_W-1:0] pay_reg;
    logic [PLEN_W-1:0] plen_reg;
    logic              has_reg;
    logic              last_reg;

    logic              ld;
    logic              ld_good;
    logic [KIND_W-1:0] ld_kind;
    logic [BYTE_W-1:0] ld_pay;
    logic              ld_has;
    logic              ld_last;

    efd_mem_req_t      mem_req;
    logic [BYTE_W-1:0] rd_data;

    logic              rx_ready;
    logic              rx_fire;
    logic              slot_free;
    logic [BYTE_W-1:0] b;
    logic [CRC_W-1:0]  crc_fed;
    logic [CRC_W-1:0]  crc_magic;
    logic [CRC_W-1:0]  len_full;
    logic [PLEN_W-1:0] plen;
    logic              rd_last;

    efd_body_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign slot_free = !out_valid_reg || ev.ready;
    assign rx_ready  = (em_reg == EM_IDLE) && slot_free;
    assign rx_fire   = rx.valid && rx_ready;
    assign b         = esc_reg ? (rx.rx_byte ^ mask_reg) : rx.rx_byte;
    assign crc_fed   = crc_feed(crc_reg, b, poly_reg);
    assign crc_magic = crc_feed(init_reg, MAGIC_BYTE, poly_reg);
    assign len_full  = {len_hi_reg, b};
    assign plen      = PLEN_W'(frame_len_reg - IDX_W'(2));
    assign rd_last   = {1'b0, rd_idx_reg} == (frame_len_reg - IDX_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= CRC_POLY_RST;
            init_reg <= CRC_INIT_RST;
            mask_reg <= ESC_MASK_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CRC_POLY: poly_reg <= cfg_data;
                CFG_CRC_INIT: init_reg <= cfg_data;
                CFG_ESC_MASK: mask_reg <= cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        esc_next         = esc_reg;
        len_hi_next      = len_hi_reg;
        frame_len_next   = frame_len_reg;
        body_pos_next    = body_pos_reg;
        crc_hi_next      = crc_hi_reg;
        crc_next         = crc_reg;
        dest_next        = dest_reg;
        cnt_next         = cnt_reg;
        ok_cnt_next      = ok_cnt_reg;
        crc_err_cnt_next = crc_err_cnt_reg;
        trunc_cnt_next   = trunc_cnt_reg;
        skip_cnt_next    = skip_cnt_reg;
        em_next          = em_reg;
        rd_idx_next      = rd_idx_reg;
        out_valid_next   = out_valid_reg && !ev.ready;
        ld               = 1'b0;
        ld_good          = 1'b0;
        ld_kind          = EV_GOOD;
        ld_pay           = '0;
        ld_has           = 1'b0;
        ld_last          = 1'b1;
        mem_req          = '0;

        if (rx_fire)
        begin
            if (rx.rx_byte == MAGIC_BYTE)
            begin
                // close an open frame as truncated, then restart
                if (phase_reg != PH_HUNT)
                begin
                    trunc_cnt_next = trunc_cnt_reg + CNT_W'(1);
                    skip_cnt_next  = skip_cnt_reg + CNT_W'(body_pos_reg);
                    ld             = 1'b1;
                    ld_kind        = EV_TRUNC;
                end
                esc_next       = 1'b0;
                frame_len_next = '0;
                body_pos_next  = '0;
                phase_next     = PH_LEN_HI;
                crc_next       = crc_magic;
            end
            else if (phase_reg == PH_HUNT)
            begin
                skip_cnt_next = skip_cnt_reg + CNT_W'(1);
            end
            else if (!esc_reg && rx.rx_byte == ESCAPE_BYTE)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                esc_next = 1'b0;
                unique case (phase_reg)
                    PH_LEN_HI:
                    begin
                        len_hi_next = b;
                        crc_next    = crc_fed;
                        phase_next  = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        crc_next      = crc_fed;
                        body_pos_next = '0;
                        if (len_full < CRC_W'(2) || len_full > CRC_W'(BODY_BYTES))
                        begin
                            trunc_cnt_next = trunc_cnt_reg + CNT_W'(1);
                            ld             = 1'b1;
                            ld_kind        = EV_TRUNC;
                            phase_next     = PH_HUNT;
                            frame_len_next = '0;
                        end
                        else
                        begin
                            frame_len_next = IDX_W'(len_full);
                            phase_next     = PH_BODY;
                        end
                    end
                    PH_BODY:
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = body_pos_reg[ADDR_W-1:0];
                        mem_req.wdata = b;
                        // keep destination and counter at hand for the results
                        if (body_pos_reg == IDX_W'(0))
                        begin
                            dest_next = b;
                        end
                        if (body_pos_reg == IDX_W'(1))
                        begin
                            cnt_next = b;
                        end
                        body_pos_next = body_pos_reg + IDX_W'(1);
                        crc_next      = crc_fed;
                        if (body_pos_next >= frame_len_reg)
                        begin
                            phase_next = PH_CRC_HI;
                        end
                    end
                    PH_CRC_HI:
                    begin
                        crc_hi_next = b;
                        phase_next  = PH_CRC_LO;
                    end
                    PH_CRC_LO:
                    begin
                        if ({crc_hi_reg, b} == crc_reg)
                        begin
                            ok_cnt_next = ok_cnt_reg + CNT_W'(1);
                            if (plen == '0)
                            begin
                                ld      = 1'b1;
                                ld_good = 1'b1;
                            end
                            else
                            begin
                                em_next     = EM_READ;
                                rd_idx_next = ADDR_W'(2);
                            end
                        end
                        else
                        begin
                            crc_err_cnt_next = crc_err_cnt_reg + CNT_W'(1);
                            ld               = 1'b1;
                            ld_kind          = EV_CRC_ERR;
                        end
                        phase_next    = PH_HUNT;
                        body_pos_next = '0;
                    end
                    default:
                    begin
                        phase_next     = PH_HUNT;
                        frame_len_next = '0;
                        body_pos_next  = '0;
                    end
                endcase
            end
        end

        unique case (em_reg)
            EM_IDLE: ;
            EM_READ:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = rd_idx_reg;
                em_next       = EM_LOAD;
            end
            EM_LOAD:
            begin
                // hold the read word until the output slot frees
                if (slot_free)
                begin
                    ld      = 1'b1;
                    ld_good = 1'b1;
                    ld_pay  = rd_data;
                    ld_has  = 1'b1;
                    ld_last = rd_last;
                    if (rd_last)
                    begin
                        em_next = EM_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + ADDR_W'(1);
                        em_next     = EM_READ;
                    end
                end
            end
            default: em_next = EM_IDLE;
        endcase

        if (ld)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            esc_reg         <= 1'b0;
            len_hi_reg      <= '0;
            frame_len_reg   <= '0;
            body_pos_reg    <= '0;
            crc_hi_reg      <= '0;
            crc_reg         <= CRC_INIT_RST;
            ok_cnt_reg      <= '0;
            crc_err_cnt_reg <= '0;
            trunc_cnt_reg   <= '0;
            skip_cnt_reg    <= '0;
            em_reg          <= EM_IDLE;
            rd_idx_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            esc_reg         <= esc_next;
            len_hi_reg      <= len_hi_next;
            frame_len_reg   <= frame_len_next;
            body_pos_reg    <= body_pos_next;
            crc_hi_reg      <= crc_hi_next;
            crc_reg         <= crc_next;
            ok_cnt_reg      <= ok_cnt_next;
            crc_err_cnt_reg <= crc_err_cnt_next;
            trunc_cnt_reg   <= trunc_cnt_next;
            skip_cnt_reg    <= skip_cnt_next;
            em_reg          <= em_next;
            rd_idx_reg      <= rd_idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dest_reg <= dest_next;
        cnt_reg  <= cnt_next;
        if (ld)
        begin
            kind_reg     <= ld_kind;
            dest_out_reg <= ld_good ? dest_reg : '0;
            cnt_out_reg  <= ld_good ? cnt_reg : '0;
            plen_reg     <= ld_good ? plen : '0;
            pay_reg      <= ld_pay;
            has_reg      <= ld_has;
            last_reg     <= ld_last;
        end
    end

    assign rx.ready          = rx_ready;
    assign ev.valid          = out_valid_reg;
    assign ev.event_kind     = kind_reg;
    assign ev.dest_byte      = dest_out_reg;
    assign ev.counter_byte   = cnt_out_reg;
    assign ev.payload_byte   = pay_reg;
    assign ev.payload_length = plen_reg;
    assign ev.has_payload    = has_reg;
    assign ev.last_of_run    = last_reg;
    // counters only move on an accepted byte, which needs the slot drained
    assign ev.ok_total        = ok_cnt_reg;
    assign ev.crc_error_total = crc_err_cnt_reg;
    assign ev.truncated_total = trunc_cnt_reg;
    assign ev.skipped_total   = skip_cnt_reg;

`ifndef ASSERT_OFF
    a_burst_in_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        em_reg != EM_IDLE |-> phase_reg == PH_HUNT)
        else $error("payload burst while a frame is open");

    a_body_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> body_pos_reg < frame_len_reg)
        else $error("body index past frame length");

    a_payload_good: assert property (@(posedge clk) disable iff (!rst_n)
        ev.valid && ev.has_payload |-> ev.event_kind == EV_GOOD && ev.payload_length != '0)
        else $error("payload byte on a non-good result");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        ev.valid && !ev.last_of_run |-> ev.has_payload && em_reg != EM_IDLE)
        else $error("open run without pending payload");

    a_burst_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        em_reg == EM_LOAD && slot_free && rd_last |=> em_reg == EM_IDLE)
        else $error("burst did not end after its last byte");
`endif

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import efd_pkg::*;
;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_BYTES   = 30;
    localparam int LONG_HOLD     = 1500;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] dest;
        logic [BYTE_W-1:0] msg_count;
        logic [BYTE_W-1:0] payload;
        logic [PLEN_W-1:0] plen;
        logic              has_payload;
        logic              last;
        logic [CNT_W-1:0]  ok_total;
        logic [CNT_W-1:0]  crc_err_total;
        logic [CNT_W-1:0]  trunc_total;
        logic [CNT_W-1:0]  skip_total;
    } frame_event_t;

    class frame_event_scoreboard;
        logic [CRC_W-1:0]  crc_poly;
        logic [CRC_W-1:0]  crc_init;
        logic [BYTE_W-1:0] esc_mask;

        phase_t            ph;
        bit                esc_pend;
        logic [15:0]       frame_len;
        int                body_pos;
        logic [BYTE_W-1:0] body_buf [BODY_BYTES];
        logic [BYTE_W-1:0] crc_hi;
        logic [CRC_W-1:0]  run_crc;
        logic [CNT_W-1:0]  ok_cnt;
        logic [CNT_W-1:0]  crc_err_cnt;
        logic [CNT_W-1:0]  trunc_cnt;
        logic [CNT_W-1:0]  skip_cnt;

        frame_event_t      expected_events [$];
        int                mismatches;
        int                events_checked;

        function new();
            set_config(CRC_POLY_RST, CRC_INIT_RST, ESC_MASK_RST);
            restart_hunt();
            crc_hi      = '0;
            run_crc     = CRC_INIT_RST;
            ok_cnt      = '0;
            crc_err_cnt = '0;
            trunc_cnt   = '0;
            skip_cnt    = '0;
            mismatches  = 0;
            events_checked = 0;
        endfunction

        function void set_config(logic [CRC_W-1:0] poly, logic [CRC_W-1:0] init,
                                 logic [BYTE_W-1:0] mask);
            crc_poly = poly;
            crc_init = init;
            esc_mask = mask;
        endfunction

        function logic [CRC_W-1:0] crc_byte(logic [CRC_W-1:0] c, logic [BYTE_W-1:0] d);
            c = c ^ {d, 8'h00};
            for (int i = 0; i < 8; i++)
                c = c[15] ? ((c << 1) ^ crc_poly) : (c << 1);
            return c;
        endfunction

        function void restart_hunt();
            ph        = PH_HUNT;
            esc_pend  = 1'b0;
            frame_len = '0;
            body_pos  = 0;
        endfunction

        function void push_event(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] d,
                                 logic [BYTE_W-1:0] c, logic [BYTE_W-1:0] p,
                                 logic [PLEN_W-1:0] pl, logic h, logic l);
            frame_event_t e;
            e.kind          = kind;
            e.dest          = d;
            e.msg_count     = c;
            e.payload       = p;
            e.plen          = pl;
            e.has_payload   = h;
            e.last          = l;
            e.ok_total      = ok_cnt;
            e.crc_err_total = crc_err_cnt;
            e.trunc_total   = trunc_cnt;
            e.skip_total    = skip_cnt;
            expected_events.push_back(e);
        endfunction

        // Advance the decoder by one accepted raw byte and queue what it emits.
        function void note_byte(logic [BYTE_W-1:0] raw);
            logic [BYTE_W-1:0] b;
            int plen;
            if (raw == MAGIC_BYTE) begin
                if (ph != PH_HUNT) begin
                    trunc_cnt++;
                    skip_cnt += body_pos;
                    push_event(EV_TRUNC, '0, '0, '0, '0, 1'b0, 1'b1);
                end
                restart_hunt();
                ph = PH_LEN_HI;
                run_crc = crc_byte(crc_init, MAGIC_BYTE);
                return;
            end
            if (ph == PH_HUNT) begin
                skip_cnt++;
                return;
            end
            if (esc_pend) begin
                esc_pend = 1'b0;
                b = raw ^ esc_mask;
            end
            else if (raw == ESCAPE_BYTE) begin
                esc_pend = 1'b1;
                return;
            end
            else
                b = raw;

            case (ph)
                PH_LEN_HI:
                begin
                    frame_len = {b, 8'h00};
                    run_crc   = crc_byte(run_crc, b);
                    ph        = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    frame_len[7:0] = b;
                    run_crc  = crc_byte(run_crc, b);
                    body_pos = 0;
                    if (frame_len < 2 || frame_len > BODY_BYTES) begin
                        trunc_cnt++;
                        restart_hunt();
                        push_event(EV_TRUNC, '0, '0, '0, '0, 1'b0, 1'b1);
                    end
                    else
                        ph = PH_BODY;
                end
                PH_BODY:
                begin
                    body_buf[body_pos] = b;
                    body_pos++;
                    run_crc = crc_byte(run_crc, b);
                    if (body_pos >= frame_len)
                        ph = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    crc_hi = b;
                    ph     = PH_CRC_LO;
                end
                PH_CRC_LO:
                begin
                    if ({crc_hi, b} == run_crc) begin
                        ok_cnt++;
                        plen = frame_len - 2;
                        if (plen == 0)
                            push_event(EV_GOOD, body_buf[0], body_buf[1], '0, '0, 1'b0, 1'b1);
                        else
                            for (int i = 0; i < plen; i++)
                                push_event(EV_GOOD, body_buf[0], body_buf[1], body_buf[i + 2],
                                           PLEN_W'(plen), 1'b1, i == plen - 1);
                    end
                    else begin
                        crc_err_cnt++;
                        push_event(EV_CRC_ERR, '0, '0, '0, '0, 1'b0, 1'b1);
                    end
                    restart_hunt();
                end
                default:
                    restart_hunt();
            endcase
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_event(frame_event_t got);
            frame_event_t want;
            string bad;
            if (expected_events.size() == 0) begin
                report($sformatf("unexpected event %h", got));
                return;
            end
            want = expected_events.pop_front();
            bad = "";
            if (got.kind !== want.kind)                   bad = {bad, " kind"};
            if (got.dest !== want.dest)                   bad = {bad, " dest"};
            if (got.msg_count !== want.msg_count)         bad = {bad, " counter"};
            if (got.payload !== want.payload)             bad = {bad, " payload"};
            if (got.plen !== want.plen)                   bad = {bad, " length"};
            if (got.has_payload !== want.has_payload)     bad = {bad, " has_payload"};
            if (got.last !== want.last)                   bad = {bad, " last"};
            if (got.ok_total !== want.ok_total)           bad = {bad, " ok_total"};
            if (got.crc_err_total !== want.crc_err_total) bad = {bad, " crc_error_total"};
            if (got.trunc_total !== want.trunc_total)     bad = {bad, " truncated_total"};
            if (got.skip_total !== want.skip_total)       bad = {bad, " skipped_total"};
            if (bad != "")
                report($sformatf("event %0d wrong%s: got %h want %h",
                                 events_checked, bad, got, want));
            events_checked++;
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    efd_byte_if  byte_ch ();
    efd_event_if event_ch ();

    escaped_frame_decoder_crc16_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (byte_ch),
        .ev        (event_ch)
    );

    frame_event_scoreboard sb = new();

    int           cycle_count;
    int           bytes_sent;
    int           hold_cycles;
    bit           tx_steady;
    bit           rx_steady;
    frame_event_t observed_event;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && byte_ch.valid && byte_ch.ready)
            sb.note_byte(byte_ch.rx_byte);
    end

    always @(posedge clk)
    begin
        if (rst_n && event_ch.valid && event_ch.ready) begin
            observed_event.kind          = event_ch.event_kind;
            observed_event.dest          = event_ch.dest_byte;
            observed_event.msg_count     = event_ch.counter_byte;
            observed_event.payload       = event_ch.payload_byte;
            observed_event.plen          = event_ch.payload_length;
            observed_event.has_payload   = event_ch.has_payload;
            observed_event.last          = event_ch.last_of_run;
            observed_event.ok_total      = event_ch.ok_total;
            observed_event.crc_err_total = event_ch.crc_error_total;
            observed_event.trunc_total   = event_ch.truncated_total;
            observed_event.skip_total    = event_ch.skipped_total;
            sb.check_event(observed_event);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Result sink: random stalls per result, plus a long hold-off on request.
    initial
    begin : result_sink
        int gap;
        event_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 31) == 0)
                rx_steady = !rx_steady;
            if (hold_cycles > 0) begin
                event_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            gap = rx_steady ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                event_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            event_ch.ready <= 1'b1;
            do @(posedge clk); while (!event_ch.valid && hold_cycles == 0);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if ($urandom_range(0, 31) == 0)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        do @(posedge clk); while (!byte_ch.ready);
        bytes_sent++;
    endtask

    // Stuff magic and escape bytes unless the escaped form would be magic; escape other bytes now and then too.
    task automatic send_coded(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] alt;
        alt = b ^ sb.esc_mask;
        if ((b == MAGIC_BYTE || b == ESCAPE_BYTE || $urandom_range(0, 9) == 0)
            && alt != MAGIC_BYTE) begin
            send_byte(ESCAPE_BYTE);
            send_byte(alt);
        end
        else
            send_byte(b);
    endtask

    // cut >= 0 drops the frame after that many unstuffed bytes.
    task automatic send_frame(input int len, input bit bad_crc, input int cut);
        logic [BYTE_W-1:0] seq [$];
        logic [CRC_W-1:0]  crc;
        seq.push_back(len[15:8]);
        seq.push_back(len[7:0]);
        for (int i = 0; i < len; i++)
            seq.push_back(BYTE_W'($urandom_range(0, 255)));
        crc = sb.crc_byte(sb.crc_init, MAGIC_BYTE);
        foreach (seq[i])
            crc = sb.crc_byte(crc, seq[i]);
        if (bad_crc)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        seq.push_back(crc[15:8]);
        seq.push_back(crc[7:0]);
        send_byte(MAGIC_BYTE);
        foreach (seq[i])
            if (cut < 0 || i < cut)
                send_coded(seq[i]);
    endtask

    task automatic random_traffic();
        int pick;
        int len;
        int bad_len;
        pick = $urandom_range(0, 99);
        len  = ($urandom_range(0, 15) == 0) ? $urandom_range(2, BODY_BYTES)
                                            : $urandom_range(2, 8);
        if (pick < 55)
            send_frame(len, 1'b0, -1);
        else if (pick < 67)
            send_frame(len, 1'b1, -1);
        else if (pick < 77)
            send_frame(len, 1'b0, $urandom_range(0, len + 3));
        else if (pick < 87) begin
            bad_len = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1)
                                                  : $urandom_range(BODY_BYTES + 1, 16'hffff);
            send_byte(MAGIC_BYTE);
            send_coded(bad_len[15:8]);
            send_coded(bad_len[7:0]);
        end
        else
            repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [CRC_W-1:0] poly, input logic [CRC_W-1:0] init,
                              input logic [BYTE_W-1:0] mask);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CRC_POLY;
        cfg_data  <= poly;
        @(posedge clk);
        cfg_index <= CFG_CRC_INIT;
        cfg_data  <= init;
        @(posedge clk);
        cfg_index <= CFG_ESC_MASK;
        cfg_data  <= {8'h00, mask};
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_config(poly, init, mask);
    endtask

    initial
    begin
        logic [BYTE_W-1:0] opening [$];
        int start;

        opening = '{
            8'h00, 8'hff, ESCAPE_BYTE, 8'h5a,
            MAGIC_BYTE, 8'h00, 8'h00,
            MAGIC_BYTE, 8'hff, 8'hff,
            MAGIC_BYTE, 8'h00, 8'h41,
            MAGIC_BYTE, ESCAPE_BYTE, ESCAPE_BYTE, 8'h00,
            MAGIC_BYTE, 8'h00, ESCAPE_BYTE
        };
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_CRC_POLY;
        cfg_data        <= '0;
        byte_ch.valid   <= 1'b0;
        byte_ch.rx_byte <= '0;
        bytes_sent  = 0;
        hold_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // hunt noise, bad lengths, escaped length, then magic with an escape pending
        foreach (opening[i])
            send_byte(opening[i]);
        send_frame(2, 1'b0, -1);
        send_frame(3, 1'b1, -1);
        send_frame(4, 1'b0, -1);

        for (int k = 0; k < 5; k++) begin
            wait_drained();
            case (k)
                0: write_regs(16'h1021, 16'hffff, 8'h20);
                1: write_regs(16'h0000, 16'h0000, 8'h00);
                2: write_regs(16'hffff, 16'hffff, 8'hff);
                3: write_regs(CRC_W'($urandom_range(0, 16'hffff)),
                              CRC_W'($urandom_range(0, 16'hffff)),
                              BYTE_W'($urandom_range(0, 8'hff)));
                default: write_regs(CRC_POLY_RST, CRC_INIT_RST, ESC_MASK_RST);
            endcase
            if (k == 0) begin
                // hold the sink while a full-size frame and more keep coming
                hold_cycles = LONG_HOLD;
                send_frame(BODY_BYTES, 1'b0, -1);
                send_frame(4, 1'b0, -1);
                send_frame(5, 1'b0, -1);
            end
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
                random_traffic();
        end

        wait_drained();
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/efd_pkg.sv
rtl/efd_byte_if.sv
rtl/efd_event_if.sv
rtl/efd_body_store.sv
rtl/escaped_frame_decoder_crc16_core.sv
sim/tb_top.sv
